/* sv/point_in_convex_mesh_test_defines.svh */
// Assertion macros shared by the point-in-mesh test block.
`ifndef POINT_IN_CONVEX_MESH_TEST_DEFINES_SVH
`define POINT_IN_CONVEX_MESH_TEST_DEFINES_SVH

// Same-cycle implication, checked on clk with rst_n low masking the check.
`define PIMT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pimt: same-cycle check failed");

// Next-cycle implication, checked on clk with rst_n low masking the check.
`define PIMT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pimt: next-cycle check failed");

`endif

/* sv/pimt_pkg.sv */
// Types, codes and helper functions of the point-in-mesh test block.
`default_nettype none
package pimt_pkg;

  // Default table depths.
  localparam int DEF_MAX_MESHES   = 8;
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_FACES    = 256;

  localparam int CORDIC_STEPS = 14;

  // Input commands.
  localparam logic [1:0] CMD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_FACE   = 2'd1;
  localparam logic [1:0] CMD_RANGE  = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ANGLE_X    = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y    = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z    = 3'd2;
  localparam logic [2:0] REG_OFFSET_X   = 3'd3;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd4;
  localparam logic [2:0] REG_OFFSET_Z   = 3'd5;
  localparam logic [2:0] REG_MESH_COUNT = 3'd6;

  // Datapath operations issued by the controller.
  localparam logic [4:0] OP_NOP       = 5'd0;
  localparam logic [4:0] OP_ACCEPT    = 5'd1;
  localparam logic [4:0] OP_CINIT     = 5'd2;
  localparam logic [4:0] OP_CSTEP     = 5'd3;
  localparam logic [4:0] OP_CFIN      = 5'd4;
  localparam logic [4:0] OP_RANGE_RD  = 5'd5;
  localparam logic [4:0] OP_RANGE_LD  = 5'd6;
  localparam logic [4:0] OP_FACE_RD   = 5'd7;
  localparam logic [4:0] OP_VTX_RD    = 5'd8;
  localparam logic [4:0] OP_VTX_LD    = 5'd9;
  localparam logic [4:0] OP_RMUL      = 5'd10;
  localparam logic [4:0] OP_RADD      = 5'd11;
  localparam logic [4:0] OP_OFS       = 5'd12;
  localparam logic [4:0] OP_DIFF      = 5'd13;
  localparam logic [4:0] OP_XMUL      = 5'd14;
  localparam logic [4:0] OP_XSUB      = 5'd15;
  localparam logic [4:0] OP_DMUL      = 5'd16;
  localparam logic [4:0] OP_MESH_NEXT = 5'd17;
  localparam logic [4:0] OP_FACE_NEXT = 5'd18;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic [7:0]         corner_a;
    logic [7:0]         corner_b;
    logic [7:0]         corner_c;
    logic [7:0]         first_face;
    logic [8:0]         face_count;
  } in_beat_t;

  typedef struct packed {
    logic       found;
    logic [2:0] mesh_index;
  } out_beat_t;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] axis;
    logic [3:0] iter;
    logic [1:0] corner;
  } dp_cmd_t;

  typedef struct packed {
    logic       m_lt_n;
    logic       f_lt_end;
    logic       excl;
    logic [2:0] mesh_idx;
  } dp_status_t;

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic signed [17:0] atan_step(input logic [3:0] i);
    logic signed [17:0] r;
    unique case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  // Saturate a 20-bit value to signed 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Round a Q14-scaled sum to nearest (ties up), then saturate.
  function automatic logic signed [15:0] rnd14(input logic signed [32:0] t);
    logic signed [33:0] r;
    logic signed [33:0] q;
    r = 34'(t) + 34'sd8192;
    q = r >>> 14;
    return sat16(q[19:0]);
  endfunction

endpackage
`default_nettype wire

/* sv/pimt_if.sv */
// Valid/ready channel interfaces for query input and result output.
`default_nettype none
interface pimt_in_if import pimt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pimt_out_if import pimt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/point_in_convex_mesh_test.sv */
// Top level of the point-in-convex-mesh test block.
// Usage: one input channel carries beats that either load a table entry
// (vertex, face, mesh face range) or ask a point query. Load beats give no
// result. A query beat gives exactly one result beat
// with found and mesh_index on the output channel.
// Query sequence: build sine and cosine for the three axes (a setup step,
// 14 CORDIC steps and a store step per axis), then for each mesh searched
// read its face range and walk its faces; a mesh that holds the point ends
// the search, and the result is then posted. The face walk is paced by the
// single vertex memory port and the one shared rotation multiplier bank
// (three corners per face, each rotated about every axis in turn).
// Walking stops at the first face that excludes the point.
// Queries are handled one at a time; load beats are taken every cycle while no query is running.
// Reset clears the configuration registers and the controller; table
// contents are undefined until written. When the receiver stalls, the result
// waits in the output register and a new beat is still accepted; a second
// query finishes its walk and then waits until the output register is free.
// The user must write configuration only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "point_in_convex_mesh_test_defines.svh"
module point_in_convex_mesh_test import pimt_pkg::*; #(
  parameter int MAX_MESHES   = DEF_MAX_MESHES,
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_FACES    = DEF_MAX_FACES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pimt_in_if.sink          in_ch,
  pimt_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  out_beat_t  out_data;

  pimt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.data.command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  pimt_dp #(
    .MAX_MESHES   (MAX_MESHES),
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_FACES    (MAX_FACES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_beat   (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // A query beat keeps the input closed while its walk runs.
  `PIMT_ASSERT_NXT(a_query_busy, in_ch.valid && in_ready && in_ch.data.command == CMD_QUERY, !in_ready)
  // A miss always reports mesh index zero.
  `PIMT_ASSERT_IMP(a_miss_index, out_valid && !out_data.found, out_data.mesh_index == 3'd0)
  // The datapath only sees an accept command while the input is open.
  `PIMT_ASSERT_IMP(a_accept_open, cmd.op == OP_ACCEPT, in_ready && in_ch.valid)

endmodule
`default_nettype wire

/* sv/pimt_dp.sv */
// Datapath: tables, configuration, sine/cosine unit, corner transform and face test.
`default_nettype none
module pimt_dp import pimt_pkg::*; #(
  parameter int MAX_MESHES   = DEF_MAX_MESHES,
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_FACES    = DEF_MAX_FACES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  input  wire in_beat_t    in_beat,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output dp_status_t       status
);

  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int FAW = $clog2(MAX_FACES);
  localparam int MAW = (MAX_MESHES > 1) ? $clog2(MAX_MESHES) : 1;
  localparam int MCW = $clog2(MAX_MESHES + 1);
  localparam int FCW = ($clog2(MAX_FACES + 1) > 10) ? $clog2(MAX_FACES + 1) : 10;

  // Configuration registers.
  logic [15:0]        angle_r [3];
  logic signed [15:0] ofs_r [3];
  logic [3:0]         mesh_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        angle_r[i] <= '0;
        ofs_r[i]   <= '0;
      end
      mesh_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ANGLE_X:    angle_r[0] <= cfg_data;
        REG_ANGLE_Y:    angle_r[1] <= cfg_data;
        REG_ANGLE_Z:    angle_r[2] <= cfg_data;
        REG_OFFSET_X:   ofs_r[0] <= cfg_data;
        REG_OFFSET_Y:   ofs_r[1] <= cfg_data;
        REG_OFFSET_Z:   ofs_r[2] <= cfg_data;
        REG_MESH_COUNT: mesh_count_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Table memories with registered reads.
  logic [47:0] vmem [MAX_VERTICES];
  logic [23:0] fmem [MAX_FACES];
  logic [16:0] rmem [MAX_MESHES];
  logic [47:0] vq_r;
  logic        vin_r;
  logic [23:0] fq_r;
  logic [16:0] rq_r;

  logic [MCW-1:0] m_r;
  logic [FCW-1:0] f_r;
  logic [FCW-1:0] end_r;

  logic [16:0] slot_ext;
  logic [7:0]  corner_sel;
  logic [16:0] vaddr_ext;
  logic        wr_beat;

  assign slot_ext = 17'(in_beat.slot);
  assign wr_beat  = (cmd.op == OP_ACCEPT);

  always_comb begin
    unique case (cmd.corner)
      2'd0:    corner_sel = fq_r[23:16];
      2'd1:    corner_sel = fq_r[15:8];
      default: corner_sel = fq_r[7:0];
    endcase
  end
  assign vaddr_ext = 17'(corner_sel);

  always_ff @(posedge clk) begin
    if (wr_beat && in_beat.command == CMD_VERTEX && slot_ext < 17'(MAX_VERTICES)) begin
      vmem[slot_ext[VAW-1:0]] <= {in_beat.coord_x, in_beat.coord_y, in_beat.coord_z};
    end
    if (cmd.op == OP_VTX_RD) begin
      vq_r  <= vmem[vaddr_ext[VAW-1:0]];
      vin_r <= (vaddr_ext < 17'(MAX_VERTICES));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_beat && in_beat.command == CMD_FACE && slot_ext < 17'(MAX_FACES)) begin
      fmem[slot_ext[FAW-1:0]] <= {in_beat.corner_a, in_beat.corner_b, in_beat.corner_c};
    end
    if (cmd.op == OP_FACE_RD) begin
      fq_r <= fmem[f_r[FAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_beat && in_beat.command == CMD_RANGE && slot_ext < 17'(MAX_MESHES)) begin
      rmem[slot_ext[MAW-1:0]] <= {in_beat.first_face, in_beat.face_count};
    end
    if (cmd.op == OP_RANGE_RD) begin
      rq_r <= rmem[m_r[MAW-1:0]];
    end
  end

  // Mesh and face walk counters.
  logic [FCW-1:0] range_end;
  assign range_end = FCW'(rq_r[16:9]) + FCW'(rq_r[8:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r   <= '0;
      f_r   <= '0;
      end_r <= '0;
    end else begin
      if (wr_beat && in_beat.command == CMD_QUERY) begin
        m_r <= '0;
      end
      if (cmd.op == OP_MESH_NEXT) begin
        m_r <= m_r + 1'b1;
      end
      if (cmd.op == OP_RANGE_LD) begin
        f_r   <= FCW'(rq_r[16:9]);
        end_r <= (range_end > FCW'(MAX_FACES)) ? FCW'(MAX_FACES) : range_end;
      end
      if (cmd.op == OP_FACE_NEXT) begin
        f_r <= f_r + 1'b1;
      end
    end
  end

  logic [7:0] mc_lim;
  logic [7:0] m_ext;
  assign mc_lim = (8'(mesh_count_r) > 8'(MAX_MESHES)) ? 8'(MAX_MESHES) : 8'(mesh_count_r);
  assign m_ext  = 8'(m_r);

  // Query point.
  logic signed [15:0] pt_r [3];
  always_ff @(posedge clk) begin
    if (wr_beat && in_beat.command == CMD_QUERY) begin
      pt_r[0] <= in_beat.coord_x;
      pt_r[1] <= in_beat.coord_y;
      pt_r[2] <= in_beat.coord_z;
    end
  end

  // Sine/cosine unit: fold, then one CORDIC step per cycle.
  logic signed [19:0] cx_r;
  logic signed [19:0] cy_r;
  logic signed [17:0] cz_r;
  logic               neg_r;
  logic               spec_r;
  logic signed [15:0] cs_r [3];
  logic signed [15:0] sn_r [3];

  logic signed [16:0] a_raw;
  logic signed [16:0] a_fold;
  logic               a_neg;
  logic signed [19:0] xs;
  logic signed [19:0] ys;
  logic signed [19:0] x_cl;
  logic signed [19:0] y_cl;
  logic signed [19:0] x_fin;
  logic signed [19:0] y_fin;

  assign a_raw = 17'(signed'(angle_r[cmd.axis]));

  always_comb begin
    a_fold = a_raw;
    a_neg  = 1'b0;
    if (a_raw > 17'sd16384) begin
      a_fold = a_raw - 17'sd32768;
      a_neg  = 1'b1;
    end else if (a_raw < -17'sd16384) begin
      a_fold = a_raw + 17'sd32768;
      a_neg  = 1'b1;
    end
  end

  assign xs = cx_r >>> cmd.iter;
  assign ys = cy_r >>> cmd.iter;

  always_comb begin
    x_cl = cx_r;
    y_cl = cy_r;
    if (cx_r > 20'sd16384) x_cl = 20'sd16384;
    if (cx_r < -20'sd16384) x_cl = -20'sd16384;
    if (cy_r > 20'sd16384) y_cl = 20'sd16384;
    if (cy_r < -20'sd16384) y_cl = -20'sd16384;
    x_fin = neg_r ? -x_cl : x_cl;
    y_fin = neg_r ? -y_cl : y_cl;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CINIT) begin
      neg_r <= a_neg;
      cz_r  <= 18'(a_fold);
      if (a_fold == 17'sd0) begin
        spec_r <= 1'b1;
        cx_r   <= 20'sd16384;
        cy_r   <= 20'sd0;
      end else if (a_fold == 17'sd16384) begin
        spec_r <= 1'b1;
        cx_r   <= 20'sd0;
        cy_r   <= 20'sd16384;
      end else if (a_fold == -17'sd16384) begin
        spec_r <= 1'b1;
        cx_r   <= 20'sd0;
        cy_r   <= -20'sd16384;
      end else begin
        spec_r <= 1'b0;
        cx_r   <= 20'sd9949;
        cy_r   <= 20'sd0;
      end
    end else if (cmd.op == OP_CSTEP && !spec_r) begin
      if (cz_r >= 18'sd0) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - atan_step(cmd.iter);
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + atan_step(cmd.iter);
      end
    end
    if (cmd.op == OP_CFIN) begin
      cs_r[cmd.axis] <= x_fin[15:0];
      sn_r[cmd.axis] <= y_fin[15:0];
    end
  end

  // Corner transform: per axis, a multiply step then a round step.
  logic signed [15:0] vx_r;
  logic signed [15:0] vy_r;
  logic signed [15:0] vz_r;
  logic signed [15:0] u_op;
  logic signed [15:0] w_op;
  logic signed [15:0] c_op;
  logic signed [15:0] s_op;
  logic signed [31:0] p_r [4];
  logic signed [15:0] nu;
  logic signed [15:0] nw;

  always_comb begin
    unique case (cmd.axis)
      AXIS_X:  begin u_op = vy_r; w_op = vz_r; end
      AXIS_Y:  begin u_op = vz_r; w_op = vx_r; end
      default: begin u_op = vx_r; w_op = vy_r; end
    endcase
  end
  assign c_op = cs_r[cmd.axis];
  assign s_op = sn_r[cmd.axis];
  assign nu   = rnd14(33'(p_r[0]) - 33'(p_r[1]));
  assign nw   = rnd14(33'(p_r[2]) + 33'(p_r[3]));

  logic signed [15:0] crn_r [3][3];

  always_ff @(posedge clk) begin
    if (cmd.op == OP_VTX_LD) begin
      vx_r <= vin_r ? vq_r[47:32] : 16'sd0;
      vy_r <= vin_r ? vq_r[31:16] : 16'sd0;
      vz_r <= vin_r ? vq_r[15:0] : 16'sd0;
    end else if (cmd.op == OP_RADD) begin
      unique case (cmd.axis)
        AXIS_X:  begin vy_r <= nu; vz_r <= nw; end
        AXIS_Y:  begin vz_r <= nu; vx_r <= nw; end
        default: begin vx_r <= nu; vy_r <= nw; end
      endcase
    end
    if (cmd.op == OP_RMUL) begin
      p_r[0] <= u_op * c_op;
      p_r[1] <= w_op * s_op;
      p_r[2] <= u_op * s_op;
      p_r[3] <= w_op * c_op;
    end
    if (cmd.op == OP_OFS) begin
      crn_r[cmd.corner][0] <= sat16(20'(vx_r) + 20'(ofs_r[0]));
      crn_r[cmd.corner][1] <= sat16(20'(vy_r) + 20'(ofs_r[1]));
      crn_r[cmd.corner][2] <= sat16(20'(vz_r) + 20'(ofs_r[2]));
    end
  end

  // Face test: edges, cross product, dot product with the point offset.
  logic signed [16:0] ea_r [3];
  logic signed [16:0] eb_r [3];
  logic signed [16:0] ed_r [3];
  logic signed [33:0] xp_r [6];
  logic signed [34:0] nrm_r [3];
  logic signed [51:0] dp_r [3];
  logic signed [53:0] dot;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIFF) begin
      for (int i = 0; i < 3; i++) begin
        ea_r[i] <= 17'(crn_r[1][i]) - 17'(crn_r[0][i]);
        eb_r[i] <= 17'(crn_r[2][i]) - 17'(crn_r[0][i]);
        ed_r[i] <= 17'(pt_r[i]) - 17'(crn_r[0][i]);
      end
    end
    if (cmd.op == OP_XMUL) begin
      xp_r[0] <= ea_r[1] * eb_r[2];
      xp_r[1] <= ea_r[2] * eb_r[1];
      xp_r[2] <= ea_r[2] * eb_r[0];
      xp_r[3] <= ea_r[0] * eb_r[2];
      xp_r[4] <= ea_r[0] * eb_r[1];
      xp_r[5] <= ea_r[1] * eb_r[0];
    end
    if (cmd.op == OP_XSUB) begin
      nrm_r[0] <= 35'(xp_r[0]) - 35'(xp_r[1]);
      nrm_r[1] <= 35'(xp_r[2]) - 35'(xp_r[3]);
      nrm_r[2] <= 35'(xp_r[4]) - 35'(xp_r[5]);
    end
    if (cmd.op == OP_DMUL) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i] <= nrm_r[i] * 52'(ed_r[i]);
      end
    end
  end

  assign dot = 54'(dp_r[0]) + 54'(dp_r[1]) + 54'(dp_r[2]);

  assign status.m_lt_n   = (m_ext < mc_lim);
  assign status.f_lt_end = (f_r < end_r);
  assign status.excl     = (dot > 54'sd0);
  assign status.mesh_idx = m_ext[2:0];

endmodule
`default_nettype wire

/* sv/pimt_ctrl.sv */
// Controller: sequences the query walk and holds the result register.
`default_nettype none
module pimt_ctrl import pimt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_ready,
  output logic            out_valid,
  output out_beat_t       out_data,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CINIT = 5'd1;
  localparam logic [4:0] S_CSTEP = 5'd2;
  localparam logic [4:0] S_CFIN  = 5'd3;
  localparam logic [4:0] S_MESH  = 5'd4;
  localparam logic [4:0] S_RANGE = 5'd5;
  localparam logic [4:0] S_FACE  = 5'd6;
  localparam logic [4:0] S_VRD   = 5'd7;
  localparam logic [4:0] S_VLD   = 5'd8;
  localparam logic [4:0] S_RMUL  = 5'd9;
  localparam logic [4:0] S_RADD  = 5'd10;
  localparam logic [4:0] S_OFS   = 5'd11;
  localparam logic [4:0] S_DIFF  = 5'd12;
  localparam logic [4:0] S_XMUL  = 5'd13;
  localparam logic [4:0] S_XSUB  = 5'd14;
  localparam logic [4:0] S_DMUL  = 5'd15;
  localparam logic [4:0] S_DSUM  = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [3:0] iter_r, iter_nxt;
  logic [1:0] corner_r, corner_nxt;
  logic       res_found_r, res_found_nxt;
  logic [2:0] res_idx_r, res_idx_nxt;
  logic       out_valid_r;
  out_beat_t  out_data_r;
  logic       load_out;

  // Next state and datapath command.
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    iter_nxt      = iter_r;
    corner_nxt    = corner_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    cmd.op        = OP_NOP;
    cmd.axis      = axis_r;
    cmd.iter      = iter_r;
    cmd.corner    = corner_r;
    in_ready      = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (in_command == CMD_QUERY) begin
            axis_nxt  = AXIS_X;
            state_nxt = S_CINIT;
          end
        end
      end
      S_CINIT: begin
        cmd.op    = OP_CINIT;
        iter_nxt  = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.op   = OP_CSTEP;
        iter_nxt = iter_r + 1'b1;
        if (iter_r == 4'(CORDIC_STEPS - 1)) state_nxt = S_CFIN;
      end
      S_CFIN: begin
        cmd.op = OP_CFIN;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_MESH;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_CINIT;
        end
      end
      S_MESH: begin
        if (status.m_lt_n) begin
          cmd.op    = OP_RANGE_RD;
          state_nxt = S_RANGE;
        end else begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          state_nxt     = S_DONE;
        end
      end
      S_RANGE: begin
        cmd.op    = OP_RANGE_LD;
        state_nxt = S_FACE;
      end
      S_FACE: begin
        if (status.f_lt_end) begin
          cmd.op     = OP_FACE_RD;
          corner_nxt = '0;
          state_nxt  = S_VRD;
        end else begin
          // Every face of this mesh kept the point: it is inside.
          res_found_nxt = 1'b1;
          res_idx_nxt   = status.mesh_idx;
          state_nxt     = S_DONE;
        end
      end
      S_VRD: begin
        cmd.op    = OP_VTX_RD;
        state_nxt = S_VLD;
      end
      S_VLD: begin
        cmd.op    = OP_VTX_LD;
        axis_nxt  = AXIS_X;
        state_nxt = S_RMUL;
      end
      S_RMUL: begin
        cmd.op    = OP_RMUL;
        state_nxt = S_RADD;
      end
      S_RADD: begin
        cmd.op = OP_RADD;
        if (axis_r == AXIS_Z) begin
          state_nxt = S_OFS;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = S_RMUL;
        end
      end
      S_OFS: begin
        cmd.op = OP_OFS;
        if (corner_r == 2'd2) begin
          state_nxt = S_DIFF;
        end else begin
          corner_nxt = corner_r + 1'b1;
          state_nxt  = S_VRD;
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        state_nxt = S_XMUL;
      end
      S_XMUL: begin
        cmd.op    = OP_XMUL;
        state_nxt = S_XSUB;
      end
      S_XSUB: begin
        cmd.op    = OP_XSUB;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        cmd.op    = OP_DMUL;
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        // A face that puts the point outside ends this mesh.
        if (status.excl) begin
          cmd.op    = OP_MESH_NEXT;
          state_nxt = S_MESH;
        end else begin
          cmd.op    = OP_FACE_NEXT;
          state_nxt = S_FACE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      iter_r      <= '0;
      corner_r    <= '0;
      res_found_r <= 1'b0;
      res_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      iter_r      <= iter_nxt;
      corner_r    <= corner_nxt;
      res_found_r <= res_found_nxt;
      res_idx_r   <= res_idx_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.found      <= res_found_r;
      out_data_r.mesh_index <= res_idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
